// ----- design/rlms_pkg.sv -----
// ----------------------------------------------------------------------------
// rlms_pkg
// shared types, codes and sizes for the rgb led multiplex scanner
// ----------------------------------------------------------------------------
package rlms_pkg;

	localparam int MAX_LEDS   = 8;
	localparam int IDX_W      = $clog2(MAX_LEDS);
	localparam int CNT_W      = 4;
	localparam int PHASE_W    = 3;
	localparam int ANODE_W    = 3;
	localparam int BRIGHT_W   = 4;
	localparam int COLOR_W    = 3;
	localparam int SEL_W      = 8;
	localparam int REQ_W      = 2;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 4;

	localparam logic [BRIGHT_W-1:0] BRIGHT_MAX = BRIGHT_W'(8);
	localparam logic [CNT_W-1:0]    COUNT_MAX  = CNT_W'(MAX_LEDS);
	localparam logic [CNT_W-1:0]    COUNT_MIN  = CNT_W'(1);

	// request codes
	localparam logic [REQ_W-1:0] REQ_TICK    = 2'd0;
	localparam logic [REQ_W-1:0] REQ_SET     = 2'd1;
	localparam logic [REQ_W-1:0] REQ_CLR_ONE = 2'd2;
	localparam logic [REQ_W-1:0] REQ_CLR_ALL = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_LED_COUNT  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS = 1'b1;

	typedef logic [COLOR_W-1:0] color_t;

endpackage

// ----- design/rlms_ifc.sv -----
// ----------------------------------------------------------------------------
// rlms item channels
// valid/ready channels for request items and drive items
// ----------------------------------------------------------------------------
interface rlms_req_if
	import rlms_pkg::*;
();
	logic                 valid;
	logic                 ready;
	logic [REQ_W-1:0]     req_type;
	logic [SEL_W-1:0]     led_select;
	logic [COLOR_W-1:0]   color_bits;

	modport source (output valid, req_type, led_select, color_bits, input ready);
	modport sink   (input valid, req_type, led_select, color_bits, output ready);
endinterface

interface rlms_res_if
	import rlms_pkg::*;
();
	logic               valid;
	logic               ready;
	logic               red_drive_n;
	logic               green_drive_n;
	logic               blue_drive_n;
	logic [ANODE_W-1:0] anode_index;
	logic               anode_on;

	modport source (output valid, red_drive_n, green_drive_n, blue_drive_n,
		anode_index, anode_on, input ready);
	modport sink   (input valid, red_drive_n, green_drive_n, blue_drive_n,
		anode_index, anode_on, output ready);
endinterface

// ----- design/rgb_led_multiplex_scanner.sv -----
// ----------------------------------------------------------------------------
// rgb_led_multiplex_scanner
// Scans a row of on/off rgb leds that share active-low colour lines. A new
// item is taken each cycle while the result register is free: the item and
// the stored state feed short compare and select logic whose outcome lands
// in a single result register, so one item per clock is the sustained rate
// while results drain; a result appears the cycle after its item is taken.
// Set-colour items, and clear-one items whose led_select is at or above
// led_count, give no result. Every other item shows the led at the scan
// index (dark when the pwm phase is not below global_brightness), then
// steps the scan index; the pwm phase steps once per frame. The input side
// stays ready while the result register is empty or being drained.
// Configuration writes (led_count clamps to 1..8, brightness clamps to 8)
// are taken at any edge with cfg_we high and are meant for an idle block.
// ----------------------------------------------------------------------------
module rgb_led_multiplex_scanner
	import rlms_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	rlms_req_if.sink              req,
	rlms_res_if.source            res,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// state
	color_t              store_q [MAX_LEDS];
	logic [IDX_W-1:0]    scan_q;
	logic [PHASE_W-1:0]  phase_q;
	logic [CNT_W-1:0]    count_q;
	logic [BRIGHT_W-1:0] bright_q;

	// result register
	logic               res_vld_q;
	logic               red_q, green_q, blue_q, anode_on_q;
	logic [ANODE_W-1:0] anode_idx_q;

	// item logic
	logic               accept;
	logic               sel_ok;
	logic               do_tick;
	color_t             store_nxt [MAX_LEDS];
	color_t             cur_col;
	logic               lit;
	logic [CNT_W-1:0]   scan_inc;
	logic [IDX_W-1:0]   scan_nxt;
	logic               phase_step;

	// configuration logic
	logic [CNT_W-1:0]    cfg_count;
	logic [BRIGHT_W-1:0] cfg_bright;

	// the result register frees up when it is empty or being taken
	assign req.ready = !res_vld_q || res.ready;
	assign accept    = req.valid && req.ready;

	assign sel_ok = req.led_select < {{(SEL_W-CNT_W){1'b0}}, count_q};

	// store update and tick decision for the item at the input
	always_comb begin
		for (int i = 0; i < MAX_LEDS; i++) begin
			store_nxt[i] = store_q[i];
		end
		do_tick = 1'b0;
		unique case (req.req_type)
			REQ_TICK: begin
				do_tick = 1'b1;
			end
			REQ_SET: begin
				if (sel_ok) begin
					store_nxt[req.led_select[IDX_W-1:0]] = req.color_bits;
				end
			end
			REQ_CLR_ONE: begin
				if (sel_ok) begin
					store_nxt[req.led_select[IDX_W-1:0]] = '0;
					do_tick = 1'b1;
				end
			end
			REQ_CLR_ALL: begin
				// only entries inside the current scan are cleared
				for (int i = 0; i < MAX_LEDS; i++) begin
					if (CNT_W'(i) < count_q) begin
						store_nxt[i] = '0;
					end
				end
				do_tick = 1'b1;
			end
			default: do_tick = 1'b0;
		endcase
	end

	// the tick sees the store after this item's clear
	assign cur_col = store_nxt[scan_q];
	assign lit     = {1'b0, phase_q} < bright_q;

	// scan wraps at led_count; phase steps when the new index is the last led
	assign scan_inc   = {{(CNT_W-IDX_W){1'b0}}, scan_q} + CNT_W'(1);
	assign scan_nxt   = (scan_inc == count_q) ? '0 : scan_inc[IDX_W-1:0];
	assign phase_step = ({{(CNT_W-IDX_W){1'b0}}, scan_nxt} == (count_q - CNT_W'(1)));

	// clamped register values
	always_comb begin
		priority if (cfg_data < COUNT_MIN) begin
			cfg_count = COUNT_MIN;
		end else if (cfg_data > COUNT_MAX) begin
			cfg_count = COUNT_MAX;
		end else begin
			cfg_count = cfg_data;
		end
		cfg_bright = (cfg_data > BRIGHT_MAX) ? BRIGHT_MAX : cfg_data;
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_LEDS; i++) begin
				store_q[i] <= '0;
			end
			scan_q   <= '0;
			phase_q  <= '0;
			count_q  <= COUNT_MAX;
			bright_q <= BRIGHT_MAX;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_LED_COUNT: begin
					count_q <= cfg_count;
					// a shrinking scan pulls the index back to the first led
					if ({{(CNT_W-IDX_W){1'b0}}, scan_q} >= cfg_count) begin
						scan_q <= '0;
					end
				end
				CFG_BRIGHTNESS: begin
					bright_q <= cfg_bright;
				end
				default: bright_q <= bright_q;
			endcase
		end else if (accept) begin
			for (int i = 0; i < MAX_LEDS; i++) begin
				store_q[i] <= store_nxt[i];
			end
			if (do_tick) begin
				scan_q <= scan_nxt;
				if (phase_step) begin
					phase_q <= phase_q + PHASE_W'(1);
				end
			end
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (accept) begin
			res_vld_q <= do_tick;
		end else if (res.ready) begin
			res_vld_q <= 1'b0;
		end
	end

	// result payload, active-low colour lines, all dark in the off phase
	always_ff @(posedge clk) begin
		if (accept && do_tick) begin
			red_q       <= !(lit && cur_col[0]);
			green_q     <= !(lit && cur_col[1]);
			blue_q      <= !(lit && cur_col[2]);
			anode_on_q  <= lit;
			anode_idx_q <= ANODE_W'(scan_q);
		end
	end

	assign res.valid         = res_vld_q;
	assign res.red_drive_n   = red_q;
	assign res.green_drive_n = green_q;
	assign res.blue_drive_n  = blue_q;
	assign res.anode_index   = anode_idx_q;
	assign res.anode_on      = anode_on_q;

	// scan index never leaves the active scan
	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		{{(CNT_W-IDX_W){1'b0}}, scan_q} < count_q)
		else $error("scan index outside led_count");

	// led_count and brightness stay within their clamped ranges
	a_cfg_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q >= COUNT_MIN && count_q <= COUNT_MAX && bright_q <= BRIGHT_MAX)
		else $error("configuration register out of range");

	// a set-colour item never produces a drive item
	a_set_silent: assert property (@(posedge clk) disable iff (!arst_n)
		accept && req.req_type == REQ_SET |=> !res_vld_q)
		else $error("set-colour item produced a result");

	// scan and phase move only on an accepted tick or a count write; this checks the phase holds without an item
	a_phase_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(phase_q))
		else $error("pwm phase moved without an item");

	// an off-phase result keeps every colour line dark
	a_dark_lines: assert property (@(posedge clk) disable iff (!arst_n)
		res_vld_q && !anode_on_q |-> red_q && green_q && blue_q)
		else $error("colour line lit in dark phase");

endmodule

// ----- verif/rlms_drive_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlms_drive_checker
// watches the request, drive and register ports of the led scanner, keeps its
// own copy of the colour store, scan position and pwm phase, and compares
// each drive item with the oldest predicted one
// ----------------------------------------------------------------------------
module rlms_drive_checker
	import rlms_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	rlms_req_if                   req,
	rlms_res_if                   res,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    mismatches,
	output int                    drives_pending,
	output int                    drives_seen
);

	typedef struct packed {
		logic               red_n;
		logic               green_n;
		logic               blue_n;
		logic [ANODE_W-1:0] anode;
		logic               lit;
	} drive_t;

	color_t              lamp_colors [MAX_LEDS];
	logic [CNT_W-1:0]    led_total;
	logic [BRIGHT_W-1:0] brightness;
	logic [CNT_W-1:0]    scan_pos;
	logic [PHASE_W-1:0]  pwm_step;
	drive_t              drive_q [$];

	// show the led under the scan, then move the scan and the pwm phase
	function automatic drive_t show_and_step();
		drive_t d;
		color_t c;
		c = lamp_colors[scan_pos[IDX_W-1:0]];
		d.anode = ANODE_W'(scan_pos);
		if ({1'b0, pwm_step} < brightness) begin
			d.red_n   = ~c[0];
			d.green_n = ~c[1];
			d.blue_n  = ~c[2];
			d.lit     = 1'b1;
		end else begin
			d.red_n   = 1'b1;
			d.green_n = 1'b1;
			d.blue_n  = 1'b1;
			d.lit     = 1'b0;
		end
		scan_pos = (scan_pos + 1'b1 == led_total) ? '0 : scan_pos + 1'b1;
		if (scan_pos == led_total - 1'b1)
			pwm_step = pwm_step + 1'b1;
		return d;
	endfunction

	function automatic void take_request(logic [REQ_W-1:0] kind, logic [SEL_W-1:0] sel,
		color_t col);
		case (kind)
			REQ_TICK: drive_q.push_back(show_and_step());
			REQ_SET: begin
				if (sel < led_total)
					lamp_colors[sel[IDX_W-1:0]] = col;
			end
			REQ_CLR_ONE: begin
				if (sel < led_total) begin
					lamp_colors[sel[IDX_W-1:0]] = '0;
					drive_q.push_back(show_and_step());
				end
			end
			REQ_CLR_ALL: begin
				for (int i = 0; i < MAX_LEDS; i++)
					if (i < led_total)
						lamp_colors[i] = '0;
				drive_q.push_back(show_and_step());
			end
		endcase
	endfunction

	function automatic void apply_register(logic [CFG_IDX_W-1:0] idx,
		logic [CFG_DATA_W-1:0] val);
		if (idx == CFG_LED_COUNT) begin
			if (val < COUNT_MIN)
				led_total = COUNT_MIN;
			else if (val > COUNT_MAX)
				led_total = COUNT_MAX;
			else
				led_total = val;
			if (scan_pos >= led_total)
				scan_pos = '0;
		end else if (idx == CFG_BRIGHTNESS) begin
			brightness = (val > BRIGHT_MAX) ? BRIGHT_MAX : val;
		end
	endfunction

	task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : track
		drive_t want;
		if (!arst_n) begin
			foreach (lamp_colors[i])
				lamp_colors[i] = '0;
			led_total  = COUNT_MAX;
			brightness = BRIGHT_MAX;
			scan_pos   = '0;
			pwm_step   = '0;
			drive_q.delete();
			drives_pending <= 0;
		end else begin
			if (cfg_we)
				apply_register(cfg_index, cfg_data);
			// drives pop before requests push: a drive never belongs to the
			// request taken at the same edge
			if (res.valid && res.ready) begin
				drives_seen++;
				if (drive_q.size() == 0) begin
					$display("%0t: unexpected drive item, anode %0d on %0b lines %b%b%b",
						$time, res.anode_index, res.anode_on, res.blue_drive_n,
						res.green_drive_n, res.red_drive_n);
					mismatches++;
				end else begin
					want = drive_q.pop_front();
					check_field("red_drive_n", 8'(want.red_n), 8'(res.red_drive_n));
					check_field("green_drive_n", 8'(want.green_n), 8'(res.green_drive_n));
					check_field("blue_drive_n", 8'(want.blue_n), 8'(res.blue_drive_n));
					check_field("anode_index", 8'(want.anode), 8'(res.anode_index));
					check_field("anode_on", 8'(want.lit), 8'(res.anode_on));
				end
			end
			if (req.valid && req.ready)
				take_request(req.req_type, req.led_select, req.color_bits);
			drives_pending <= drive_q.size();
		end
	end

endmodule

// ----- verif/tb_rgb_led_multiplex_scanner.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rgb_led_multiplex_scanner
// drives request items and register writes into the led scanner under random
// sender and receiver gaps; a side checker predicts every drive item and
// compares it, this module only makes stimulus and gives the verdict
// ----------------------------------------------------------------------------
module tb_rgb_led_multiplex_scanner;
	import rlms_pkg::*;

	// longest correct stretch with no handshake is the receiver hold-off
	// below plus the register writes; the limit is several times that
	localparam int IDLE_LIMIT   = 2000;
	localparam int HOLD_CYCLES  = 300;
	localparam int PHASE_ITEMS  = 200;
	localparam int BURST_ITEMS  = 24;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int mismatches;
	int drives_left;
	int drives_seen;

	int send_idle_pct;
	int recv_idle_pct;
	int hold_requests;
	int hold_served;
	int hold_left;
	int stall_cycles;
	int items_sent;
	int cur_count;
	int settings_used;

	rlms_req_if req_ch ();
	rlms_res_if res_ch ();

	rgb_led_multiplex_scanner dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.res       (res_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	rlms_drive_checker drive_chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.req            (req_ch),
		.res            (res_ch),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.mismatches     (mismatches),
		.drives_pending (drives_left),
		.drives_seen    (drives_seen)
	);

	// 2 ns clock
	always #1 clk = ~clk;

	// receiver side: random stalls, or a long hold-off whenever the stimulus
	// bumps hold_requests; the hold-off is counted here, not by the sender
	always @(posedge clk) begin
		if (arst_n) begin
			if (hold_requests != hold_served) begin
				hold_served = hold_requests;
				hold_left   = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// watchdog: cycles in a row with no handshake on either channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= IDLE_LIMIT) begin
				$display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
				$display("tb_rgb_led_multiplex_scanner: FAIL");
				$finish;
			end
		end
	end

	// offer one request item, with random sender gaps in front of it
	task automatic send_item(logic [REQ_W-1:0] kind, logic [SEL_W-1:0] sel, color_t col);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.req_type   <= kind;
		req_ch.led_select <= sel;
		req_ch.color_bits <= col;
		do @(posedge clk); while (!req_ch.ready);
		items_sent++;
	endtask

	// sender pauses until every predicted drive has come back, then lets the
	// single-register pipeline settle in case a no-result item is still inside
	task automatic drain_drives();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (drives_left != 0);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		// keep the clamped count so random selects mostly land in range
		if (idx == CFG_LED_COUNT)
			cur_count = (val == 0) ? 1 : (val > MAX_LEDS) ? MAX_LEDS : val;
	endtask

	// mostly ticks and in-range sets and clears, with some out-of-range selects
	task automatic random_item();
		int               pick;
		logic [REQ_W-1:0] kind;
		logic [SEL_W-1:0] sel;
		pick = $urandom_range(99);
		if (pick < 40)
			kind = REQ_TICK;
		else if (pick < 70)
			kind = REQ_SET;
		else if (pick < 90)
			kind = REQ_CLR_ONE;
		else
			kind = REQ_CLR_ALL;
		if ($urandom_range(99) < 80)
			sel = SEL_W'($urandom_range(cur_count - 1));
		else
			sel = SEL_W'($urandom_range(255));
		send_item(kind, sel, COLOR_W'($urandom_range(7)));
	endtask

	// one register setting with random traffic under it; raw values are
	// written so that the clamps on both registers get exercised
	task automatic run_setting(logic [CFG_DATA_W-1:0] count_raw,
		logic [CFG_DATA_W-1:0] bright_raw);
		drain_drives();
		write_reg(CFG_LED_COUNT, count_raw);
		write_reg(CFG_BRIGHTNESS, bright_raw);
		settings_used++;
		repeat (PHASE_ITEMS) random_item();
	endtask

	initial begin
		// every input known from time zero
		req_ch.valid      = 1'b0;
		req_ch.req_type   = REQ_TICK;
		req_ch.led_select = '0;
		req_ch.color_bits = '0;
		res_ch.ready      = 1'b0;
		cfg_we            = 1'b0;
		cfg_index         = CFG_LED_COUNT;
		cfg_data          = '0;
		hold_requests     = 0;
		hold_served       = 0;
		hold_left         = 0;
		stall_cycles      = 0;
		items_sent        = 0;
		cur_count         = MAX_LEDS;
		settings_used     = 1;
		send_idle_pct     = 16;
		recv_idle_pct     = 59;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset colours, full palette, ignored selects, both clears
		send_item(REQ_TICK, 8'd0, 3'd0);
		for (int i = 0; i < MAX_LEDS; i++)
			send_item(REQ_SET, SEL_W'(i), COLOR_W'(i));
		send_item(REQ_SET, 8'd255, 3'd7);
		repeat (MAX_LEDS) send_item(REQ_TICK, 8'd0, 3'd0);
		send_item(REQ_CLR_ONE, 8'd3, 3'd0);
		send_item(REQ_CLR_ONE, 8'd255, 3'd7);
		send_item(REQ_CLR_ONE, 8'd8, 3'd0);
		send_item(REQ_CLR_ALL, 8'd170, 3'd5);
		send_item(REQ_TICK, 8'd85, 3'd2);
		// dark phase: brightness zero keeps every line high
		drain_drives();
		write_reg(CFG_BRIGHTNESS, 4'd0);
		send_item(REQ_SET, 8'd0, 3'd7);
		send_item(REQ_TICK, 8'd0, 3'd0);
		send_item(REQ_TICK, 8'd0, 3'd0);

		// sender gaps light, receiver stalls heavy; count moves under the scan
		run_setting(4'd8, 4'd8);
		run_setting(4'd1, 4'd0);
		run_setting(4'd3, 4'd5);

		// the other way round, with clamped writes on both registers
		send_idle_pct = 59;
		recv_idle_pct = 16;
		run_setting(4'd15, 4'd9);
		run_setting(4'd0, 4'd15);
		run_setting(4'd5, 4'd1);

		// no gaps on either side
		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_setting(4'd7, 4'd4);

		// back-pressure: receiver holds off while ticks keep coming, so the
		// result register fills and the request side stalls
		drain_drives();
		hold_requests <= hold_requests + 1;
		repeat (BURST_ITEMS)
			send_item(REQ_TICK, SEL_W'($urandom_range(255)), COLOR_W'($urandom_range(7)));

		run_setting(4'd2, 4'd8);
		run_setting(4'd8, 4'd3);

		drain_drives();
		$display("run covered %0d request items and %0d drive items checked", items_sent,
			drives_seen);
		$display("over %0d register settings, with stalls on both sides", settings_used);
		if (mismatches == 0 && drives_left == 0)
			$display("tb_rgb_led_multiplex_scanner: PASS");
		else
			$display("tb_rgb_led_multiplex_scanner: FAIL");
		$finish;
	end

endmodule

// ----- filelist.f -----
design/rlms_pkg.sv
design/rlms_ifc.sv
design/rgb_led_multiplex_scanner.sv
verif/rlms_drive_checker.sv
verif/tb_rgb_led_multiplex_scanner.sv
